[sv/iu_pkg.sv]
package iu_pkg;

  // default sizes of the interval table
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int BOUND_BITS_DEF  = 48;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

endpackage

[sv/iu_if.sv]
// interval input channel
interface iu_in_if
  import iu_pkg::*;
#(
  parameter int BOUND_BITS = BOUND_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [BOUND_BITS-1:0] range_low;
  logic [BOUND_BITS-1:0] range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

// covered-count result channel
interface iu_out_if
  import iu_pkg::*;
#(
  parameter int BOUND_BITS = BOUND_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [BOUND_BITS:0] total_covered;
  status_t             status;

  modport source (output valid, output total_covered, output status, input ready);
  modport sink   (input valid, input total_covered, input status, output ready);
endinterface

[sv/iu_table.sv]
module iu_table
  import iu_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int WIDTH = 2 * BOUND_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/iu_scan.sv]
module iu_scan
  import iu_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int BOUND_BITS  = BOUND_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // interval transaction
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [BOUND_BITS-1:0]          in_low,
  input  logic [BOUND_BITS-1:0]          in_high,
  // table port
  output logic                           mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
  output logic [2*BOUND_BITS:0]          mem_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
  input  logic [2*BOUND_BITS:0]          mem_rdata,
  // result transaction
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [BOUND_BITS:0]            res_total,
  output status_t                        res_status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int WW = 2 * BOUND_BITS + 1;
  localparam int SW = BOUND_BITS + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINAL, ST_RESULT
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  ev_valid_r, ev_valid_nxt;
  logic [AW-1:0]         ev_idx_r, ev_idx_nxt;
  logic [BOUND_BITS-1:0] lo_r, lo_nxt;
  logic [BOUND_BITS-1:0] hi_r, hi_nxt;
  logic                  empty_r, empty_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [AW-1:0]         free_idx_r, free_idx_nxt;
  logic                  sub_valid_r, sub_valid_nxt;
  logic [BOUND_BITS-1:0] sub_lo_r, sub_lo_nxt;
  logic [BOUND_BITS-1:0] sub_hi_r, sub_hi_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [SW-1:0]         span_r, span_nxt;

  logic                  s_used;
  logic [BOUND_BITS-1:0] s_lo;
  logic [BOUND_BITS-1:0] s_hi;
  logic                  hit;
  logic                  inserted;

  assign s_used = mem_rdata[WW-1];
  assign s_lo   = mem_rdata[WW-2:BOUND_BITS];
  assign s_hi   = mem_rdata[BOUND_BITS-1:0];

  // stored entry shares an integer with the running interval
  assign hit = ev_valid_r && s_used && (lo_r <= s_hi) && (hi_r >= s_lo);

  assign inserted   = !empty_r && free_found_r;
  assign in_ready   = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_RESULT);
  assign res_total  = inserted ? (sum_r + span_r) : sum_r;
  assign res_status = empty_r ? STAT_EMPTY : (free_found_r ? STAT_OK : STAT_FULL);
  assign mem_raddr  = idx_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    ev_valid_nxt   = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    empty_nxt      = empty_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    sub_valid_nxt  = 1'b0;
    sub_lo_nxt     = sub_lo_r;
    sub_hi_nxt     = sub_hi_r;
    sum_nxt        = sum_r;
    span_nxt       = span_r;
    mem_we         = 1'b0;
    mem_waddr      = ev_idx_r;
    mem_wdata      = {1'b0, s_lo, s_hi};

    // evaluate the entry read last cycle: fold, retire, track first free slot
    if (hit) begin
      lo_nxt        = (s_lo < lo_r) ? s_lo : lo_r;
      hi_nxt        = (s_hi > hi_r) ? s_hi : hi_r;
      mem_we        = 1'b1;
      sub_valid_nxt = 1'b1;
      sub_lo_nxt    = s_lo;
      sub_hi_nxt    = s_hi;
    end
    if (ev_valid_r && !free_found_r && (!s_used || hit)) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = ev_idx_r;
    end

    // remove the span of a retired entry: sum - (hi - lo + 1)
    if (sub_valid_r) begin
      sum_nxt = sum_r + SW'(sub_lo_r) + ~SW'(sub_hi_r);
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = '0;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          lo_nxt         = in_low;
          hi_nxt         = in_high;
          empty_nxt      = (in_low > in_high);
          free_found_nxt = 1'b0;
          idx_nxt        = '0;
          state_nxt      = (in_low > in_high) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ev_valid_nxt = 1'b1;
        ev_idx_nxt   = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        // write the merged interval into the first free slot
        span_nxt = SW'(hi_r) - SW'(lo_r) + SW'(1);
        if (free_found_r) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_r;
          mem_wdata = {1'b1, lo_r, hi_r};
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
          if (inserted) begin
            sum_nxt = sum_r + span_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      ev_valid_r   <= 1'b0;
      sub_valid_r  <= 1'b0;
      free_found_r <= 1'b0;
      empty_r      <= 1'b0;
      sum_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      ev_valid_r   <= ev_valid_nxt;
      sub_valid_r  <= sub_valid_nxt;
      free_found_r <= free_found_nxt;
      empty_r      <= empty_nxt;
      sum_r        <= sum_nxt;
    end
    ev_idx_r   <= ev_idx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    free_idx_r <= free_idx_nxt;
    sub_lo_r   <= sub_lo_nxt;
    sub_hi_r   <= sub_hi_nxt;
    span_r     <= span_nxt;
  end

  // no table writes while waiting for a transaction
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_we)
    else $error("table written while idle");

  // a non-empty interval starts its scan at entry zero
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(in_low > in_high)) |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("scan did not start at entry zero");

  // writes during the scan only retire entries
  a_scan_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR && state_r != ST_FINAL) |-> !mem_wdata[WW-1])
    else $error("scan write sets a used bit");

  // read data is only evaluated while the scan runs
  a_eval_window: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("entry evaluated outside the scan");

  // a taken result returns the engine to idle
  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && res_ready) |=> state_r == ST_IDLE)
    else $error("engine stuck after result");

endmodule

[sv/interval_union_merge.sv]
// interval union merge
// Keeps a table of disjoint closed intervals and the count of integers they
// cover. Each transaction on in_ch carries [range_low, range_high]; every
// stored interval that overlaps it is folded in and retired, and the merged
// interval goes to the lowest free slot. Exactly one transaction on out_ch
// follows each input: total_covered after the item and a status (inserted or
// merged, table full and dropped, or empty interval ignored).
// Timing: one table entry is read per cycle from a single-port-read memory
// during the scan, which covers the whole table for a non-empty item; an
// empty item goes straight to its result. One item is in flight at a time;
// in_ch.ready is high only while the engine is idle, so a new item is taken
// only after the previous one has handed its result on.
// Results sit in an output register, so the next item is accepted while the
// previous result still waits; if out_ch stays stalled the engine holds the
// next result and stops taking input.
// Reset (synchronous, active low) starts a clearing pass over the table;
// in_ch.ready stays low until it ends. The covered count resets to zero.
module interval_union_merge
  import iu_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int BOUND_BITS  = BOUND_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  iu_in_if.sink    in_ch,
  iu_out_if.source out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int WW = 2 * BOUND_BITS + 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WW-1:0]         mem_rdata;
  logic                  res_valid;
  logic                  res_ready;
  logic [BOUND_BITS:0]   res_total;
  status_t               res_status;

  logic                  out_valid_r;
  logic [BOUND_BITS:0]   out_total_r;
  status_t               out_status_r;

  iu_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  iu_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .BOUND_BITS  (BOUND_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_low     (in_ch.range_low),
    .in_high    (in_ch.range_high),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_total  (res_total),
    .res_status (res_status)
  );

  // output register takes a result whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_total_r  <= res_total;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.total_covered = out_total_r;
  assign out_ch.status        = out_status_r;

endmodule
